>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on an explicit clock and active-low reset.
`define ASSERT_CLKRST(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Assert a property on the default clk / rst_n pair.
`define ASSERT_DEF(lbl, prop, msg) \
    `ASSERT_CLKRST(lbl, clk, rst_n, prop, msg)

`endif

>>> rtl/core/wtosc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtosc_pkg
// Shared widths, table geometry and request codes of the wavetable oscillator.
// ----------------------------------------------------------------------------
package wtosc_pkg;

    localparam int TABLE_SIZE  = 1024;
    localparam int TABLE_DEPTH = TABLE_SIZE + 1;
    localparam int PHASE_W     = 32;
    localparam int IDX_W       = $clog2(TABLE_SIZE);
    localparam int FRAC_W      = PHASE_W - IDX_W;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SAMPLE_W    = 16;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int PROD_W      = DIFF_W + FRAC_W + 1;
    localparam int REQ_W       = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_PHASE  = 2'd2
    } req_t;

endpackage

>>> rtl/core/wavetable_oscillator_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_oscillator_interp
// Wavetable oscillator with 32-bit phase accumulator and linear interpolation.
// ----------------------------------------------------------------------------
// One beat is taken per clock unless stalled. A sample request reads both
// neighbor entries from the 1025-entry table memory through its two registered
// read ports, advances the phase in the same cycle, and delivers its sample
// via the read, multiply and add registers. Table writes and phase loads
// finish in the cycle they are taken and give no result. The table powers up
// unknown and is not cleared: load every entry a sample can touch, including
// the guard entry 1024 as a copy of entry 0, before requesting samples.
// ----------------------------------------------------------------------------
module wavetable_oscillator_interp import wtosc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [REQ_W-1:0]           req_type,
    input  logic [PHASE_W-1:0]         phase_step,
    input  logic [ADDR_W-1:0]          table_addr,
    input  logic signed [SAMPLE_W-1:0] entry_value,
    input  logic [PHASE_W-1:0]         phase_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out
);

    logic signed [SAMPLE_W-1:0] wave_mem [0:TABLE_DEPTH-1];

    logic [PHASE_W-1:0]         phase_reg;
    logic [PHASE_W-1:0]         phase_next;
    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [SAMPLE_W-1:0] b_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic [IDX_W-1:0]           idx;
    logic [ADDR_W-1:0]          addr_a;
    logic [ADDR_W-1:0]          addr_b;
    logic                       s1_ready;
    logic                       en1;
    logic                       accept;
    logic                       wr_en;
    logic                       rd_en;

    assign en1      = !s1_valid_reg || s1_ready;
    assign in_stall = !en1;
    assign accept   = in_valid && en1;

    assign idx    = phase_reg[PHASE_W-1 -: IDX_W];
    assign addr_a = {1'b0, idx};
    assign addr_b = addr_a + ADDR_W'(1);

    assign rd_en = accept && (req_type == REQ_SAMPLE);
    assign wr_en = accept && (req_type == REQ_WRITE) && (table_addr <= ADDR_W'(TABLE_SIZE));

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (req_t'(req_type))
                REQ_SAMPLE: phase_next = phase_reg + phase_step;
                REQ_PHASE:  phase_next = phase_value;
                default:    phase_next = phase_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (en1)
                s1_valid_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            wave_mem[table_addr] <= entry_value;
        if (rd_en)
        begin
            a_reg    <= wave_mem[addr_a];
            b_reg    <= wave_mem[addr_b];
            frac_reg <= phase_reg[FRAC_W-1:0];
        end
    end

    wtosc_interp u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid_reg),
        .s1_ready   (s1_ready),
        .entry_a    (a_reg),
        .entry_b    (b_reg),
        .frac       (frac_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

endmodule

>>> rtl/core/wtosc_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtosc_interp
// Two-stage linear interpolation: multiply the neighbor difference by the
// phase fraction, then add the floored quotient back to the lower entry.
// ----------------------------------------------------------------------------
module wtosc_interp import wtosc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s1_valid,
    output logic                       s1_ready,
    input  logic signed [SAMPLE_W-1:0] entry_a,
    input  logic signed [SAMPLE_W-1:0] entry_b,
    input  logic        [FRAC_W-1:0]   frac,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out
);

    logic                         s2_valid_reg;
    logic                         out_valid_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [SAMPLE_W-1:0]   a2_reg;
    logic signed [SAMPLE_W-1:0]   sample_reg;
    logic signed [DIFF_W-1:0]     diff;
    logic signed [PROD_W-1:0]     prod;
    logic        [PROD_W-FRAC_W-1:0] quot;
    logic        [PROD_W-FRAC_W-1:0] sum;
    logic                         en_out;
    logic                         en2;

    assign en_out   = !out_valid_reg || !out_stall;
    assign en2      = !s2_valid_reg || en_out;
    assign s1_ready = en2;

    assign diff = {entry_b[SAMPLE_W-1], entry_b} - {entry_a[SAMPLE_W-1], entry_a};
    assign prod = diff * $signed({1'b0, frac});
    assign quot = prod_reg[PROD_W-1:FRAC_W];
    assign sum  = {{(PROD_W-FRAC_W-SAMPLE_W){a2_reg[SAMPLE_W-1]}}, a2_reg} + quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en2)
                s2_valid_reg <= s1_valid;
            if (en_out)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid)
        begin
            prod_reg <= prod;
            a2_reg   <= entry_a;
        end
        if (en_out && s2_valid_reg)
            sample_reg <= sum[SAMPLE_W-1:0];
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;

endmodule

>>> rtl/core/wtosc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtosc_checker
// Port-level checks of beat accounting, input stall, latency and output hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wtosc_checker import wtosc_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic [REQ_W-1:0]           req_type,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic signed [SAMPLE_W-1:0] sample_out
);

    localparam logic [2:0] PIPE_DEPTH = 3'd3;

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       sample_beat;
    logic       out_beat;
    logic       out_held;
    logic       full_stall;

    assign sample_beat = in_valid && !in_stall && (req_type == REQ_SAMPLE);
    assign out_beat    = out_valid && !out_stall;
    assign out_held    = out_valid && out_stall;
    assign full_stall  = (pending_reg == PIPE_DEPTH) && out_held;

    always_comb
    begin
        pending_next = pending_reg + {2'b00, sample_beat} - {2'b00, out_beat};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    `ASSERT_DEF(a_out_has_source, out_beat |-> (pending_reg != '0), "unexpected result beat")
    `ASSERT_DEF(a_stall_only_full, in_stall |-> full_stall, "input stalled with room left")
    `ASSERT_DEF(a_latency, (sample_beat ##1 !out_stall [*2]) |=> out_valid, "late sample")
    `ASSERT_DEF(a_out_hold, out_held |=> (out_valid && $stable(sample_out)), "held beat changed")

endmodule

bind wavetable_oscillator_interp wtosc_checker u_wtosc_checker (.*);

>>> test/tb_wavetable_oscillator_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wavetable_oscillator_interp
// Self-checking bench for the interpolating wavetable oscillator.
// ----------------------------------------------------------------------------
// Table writes, phase loads and sample requests go through the input channel
// with random gaps. A local copy of the table and phase accumulator predicts
// every interpolated sample. The output channel is stalled at random and each
// sample beat is compared in order against the predicted queue. Some samples
// read entries that were not yet written. Reserved request codes are sent too.
// ----------------------------------------------------------------------------
module tb_wavetable_oscillator_interp;
    import wtosc_pkg::*;

    localparam logic [REQ_W-1:0] REQ_RSVD = 2'd3;
    localparam int IDLE_LIMIT = 1000;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [REQ_W-1:0]           req_type;
    logic [PHASE_W-1:0]         phase_step;
    logic [ADDR_W-1:0]          table_addr;
    logic signed [SAMPLE_W-1:0] entry_value;
    logic [PHASE_W-1:0]         phase_value;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] sample_out;

    logic signed [SAMPLE_W-1:0] wave_tbl_model [TABLE_DEPTH];
    logic [PHASE_W-1:0]         phase_model;
    logic signed [SAMPLE_W-1:0] sample_q [$];
    int                         err_count;
    int                         idle_cycles;
    int                         beat_count;
    bit                         tx_calm;
    bit                         rx_calm;

    wavetable_oscillator_interp dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .phase_step  (phase_step),
        .table_addr  (table_addr),
        .entry_value (entry_value),
        .phase_value (phase_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic signed [SAMPLE_W-1:0] interp_sample(input logic [PHASE_W-1:0] ph);
        int     idx;
        longint lo;
        longint hi;
        longint acc;
        idx = int'(ph[PHASE_W-1 -: IDX_W]);
        lo  = longint'(wave_tbl_model[idx]);
        hi  = longint'(wave_tbl_model[idx + 1]);
        acc = (hi - lo) * longint'({1'b0, ph[FRAC_W-1:0]});
        acc = lo + (acc >>> FRAC_W);
        return acc[SAMPLE_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'($urandom());
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_val();
        return SAMPLE_W'($urandom());
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_entry();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return rand_val();
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic apply_beat(input logic [REQ_W-1:0] req, input logic [PHASE_W-1:0] step,
                              input logic [ADDR_W-1:0] addr,
                              input logic signed [SAMPLE_W-1:0] val,
                              input logic [PHASE_W-1:0] pv);
        case (req)
            REQ_SAMPLE:
            begin
                sample_q.push_back(interp_sample(phase_model));
                phase_model = phase_model + step;
            end
            REQ_WRITE:
            begin
                if (addr <= TABLE_SIZE)
                    wave_tbl_model[addr] = val;
            end
            REQ_PHASE: phase_model = pv;
            default: ;
        endcase
    endtask

    task automatic send_beat(input logic [REQ_W-1:0] req, input logic [PHASE_W-1:0] step,
                             input logic [ADDR_W-1:0] addr,
                             input logic signed [SAMPLE_W-1:0] val,
                             input logic [PHASE_W-1:0] pv);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        phase_step  <= step;
        table_addr  <= addr;
        entry_value <= val;
        phase_value <= pv;
        do @(posedge clk); while (in_stall);
        apply_beat(req, step, addr, val, pv);
        beat_count++;
    endtask

    task automatic wait_idle(input int tail);
        in_valid <= 1'b0;
        while (sample_q.size() != 0) @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic test_extremes();
        send_beat(REQ_WRITE, $urandom(), 11'd0, 16'sh7FFF, $urandom());
        send_beat(REQ_WRITE, $urandom(), 11'd1, 16'sh8000, $urandom());
        send_beat(REQ_SAMPLE, 32'h003F_FFFF, rand_addr(), rand_val(), $urandom());
        send_beat(REQ_SAMPLE, 32'hFFFF_FFFF, rand_addr(), rand_val(), $urandom());
        send_beat(REQ_SAMPLE, 32'h0000_0000, rand_addr(), rand_val(), $urandom());
    endtask

    task automatic test_phase_wrap();
        send_beat(REQ_WRITE, $urandom(), 11'd1023, 16'sh8000, $urandom());
        send_beat(REQ_WRITE, $urandom(), 11'd1024, 16'sh7FFF, $urandom());
        send_beat(REQ_PHASE, $urandom(), rand_addr(), rand_val(), 32'hFFFF_FFFF);
        send_beat(REQ_SAMPLE, 32'h0000_0001, rand_addr(), rand_val(), $urandom());
        send_beat(REQ_SAMPLE, 32'h8000_0000, rand_addr(), rand_val(), $urandom());
        send_beat(REQ_PHASE, $urandom(), rand_addr(), rand_val(), 32'hFFC0_0000);
        send_beat(REQ_SAMPLE, 32'h0040_0000, rand_addr(), rand_val(), $urandom());
    endtask

    task automatic test_ignored_requests();
        send_beat(REQ_WRITE, $urandom(), 11'd1025, rand_val(), $urandom());
        send_beat(REQ_WRITE, $urandom(), 11'd2047, rand_val(), $urandom());
        send_beat(REQ_RSVD, $urandom(), rand_addr(), rand_val(), $urandom());
        send_beat(REQ_RSVD, $urandom(), 11'd1, rand_val(), 32'h8000_0000);
        send_beat(REQ_PHASE, $urandom(), rand_addr(), rand_val(), 32'h0000_0000);
        send_beat(REQ_SAMPLE, 32'h0000_0000, rand_addr(), rand_val(), $urandom());
        send_beat(REQ_PHASE, $urandom(), rand_addr(), rand_val(), 32'h003F_FFFF);
        send_beat(REQ_SAMPLE, 32'h0000_0000, rand_addr(), rand_val(), $urandom());
        send_beat(REQ_PHASE, $urandom(), rand_addr(), rand_val(), 32'hFFFF_FFFF);
        send_beat(REQ_SAMPLE, 32'h0000_0001, rand_addr(), rand_val(), $urandom());
    endtask

    task automatic test_table_load();
        for (int a = 0; a <= TABLE_SIZE; a++)
        begin
            tx_calm = (a < TABLE_SIZE / 2);
            send_beat(REQ_WRITE, $urandom(), ADDR_W'(a), pick_entry(), $urandom());
        end
        tx_calm = 1'b0;
    endtask

    task automatic test_random_traffic(input int count);
        int                         kind;
        logic [PHASE_W-1:0]         step;
        logic [PHASE_W-1:0]         pv;
        logic [ADDR_W-1:0]          addr;
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                case ($urandom_range(0, 5))
                    0: step = 32'h0000_0000;
                    1: step = 32'hFFFF_FFFF;
                    2: step = $urandom_range(0, 32'h0100_0000);
                    default: step = $urandom();
                endcase
                send_beat(REQ_SAMPLE, step, rand_addr(), rand_val(), $urandom());
            end
            else if (kind < 75)
            begin
                if ($urandom_range(0, 9) == 0)
                    addr = ADDR_W'($urandom_range(TABLE_SIZE + 1, 2047));
                else
                    addr = ADDR_W'($urandom_range(0, TABLE_SIZE));
                send_beat(REQ_WRITE, $urandom(), addr, pick_entry(), $urandom());
            end
            else if (kind < 90)
            begin
                pv = $urandom();
                case ($urandom_range(0, 4))
                    0: pv[FRAC_W-1:0] = '0;
                    1: pv[FRAC_W-1:0] = '1;
                    2: pv = '0;
                    default: ;
                endcase
                send_beat(REQ_PHASE, $urandom(), rand_addr(), rand_val(), pv);
            end
            else
                send_beat(REQ_RSVD, $urandom(), rand_addr(), rand_val(), $urandom());
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    task automatic test_drain_pause();
        wait_idle(4);
    endtask

    initial
    begin
        int                         stall_len;
        logic signed [SAMPLE_W-1:0] want;
        @(posedge rst_n);
        forever
        begin
            stall_len = rx_calm ? 0 : $urandom_range(0, 4);
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            if (sample_q.size() == 0)
                report_mismatch($sformatf("sample %0d with none expected", sample_out));
            else
            begin
                want = sample_q.pop_front();
                if (sample_out !== want)
                    report_mismatch($sformatf("sample_out got %0d want %0d", sample_out, want));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        err_count   = 0;
        idle_cycles = 0;
        beat_count  = 0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        phase_model = '0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        req_type    <= REQ_SAMPLE;
        phase_step  <= '0;
        table_addr  <= '0;
        entry_value <= '0;
        phase_value <= '0;
        out_stall   <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_phase_wrap();
        test_ignored_requests();
        test_table_load();
        test_random_traffic(250);
        test_drain_pause();
        test_random_traffic(260);

        wait_idle(16);
        if (err_count == 0 && sample_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
